@@ src/encoder_sample_validator_macros.svh @@
// Assertion macros for the encoder sample validator checker.
// Used by esv_checker; needs a clock and a reset named clock and reset in scope.
`ifndef ENCODER_SAMPLE_VALIDATOR_MACROS_SVH
`define ENCODER_SAMPLE_VALIDATOR_MACROS_SVH

// check a property outside reset
`define ESV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define ESV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/esv_pkg.sv @@
// Shared types, codes and constants of the encoder sample validator.
// No dependencies; every other file of the block but the macro header uses it.
package esv_pkg;

   localparam int PORTS_DEFAULT        = 6;
   localparam int ERROR_KINDS_DEFAULT  = 3;
   localparam int COUNTER_BITS_DEFAULT = 16;

   localparam int CSR_DATA_BITS  = 16;
   localparam int PORT_TYPE_BITS = 2;
   localparam int PORT_BITS      = 3;
   localparam int RAW_BITS       = 32;
   localparam int POSITION_BITS  = 16;
   localparam int WINDOW_BITS    = 14;
   localparam int THRESHOLD_BITS = 16;
   localparam int PARITY_SPAN    = 18;

   localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET = 14'd10000;

   // queue between classifier and executor
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int QUEUE_CNT_BITS  = 2;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // encoder kinds held in the port type registers
   localparam logic [PORT_TYPE_BITS-1:0] PTYPE_NONE   = 2'd0;
   localparam logic [PORT_TYPE_BITS-1:0] PTYPE_PARITY = 2'd1;
   localparam logic [PORT_TYPE_BITS-1:0] PTYPE_PLAIN  = 2'd2;

   // status field expected in bits 5:3 of a parity-checked word
   localparam logic [2:0] STATUS_GOOD = 3'b100;

   // error counter kinds per port
   localparam int KIND_LINK   = 0;
   localparam int KIND_PARITY = 1;
   localparam int KIND_STATUS = 2;

   typedef struct packed {
      logic                     operation;
      logic [PORT_BITS-1:0]     port;
      logic [RAW_BITS-1:0]      raw_word;
      logic                     link_ok;
   } req_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic                     check_error;
      logic                     link_error;
      logic                     unconfigured;
      logic                     alarm;
      logic [WINDOW_BITS-1:0]   window_count;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                     tick;
      logic [PORT_BITS-1:0]     port;
      logic [POSITION_BITS-1:0] position;
      logic                     link_err;
      logic                     parity_err;
      logic                     status_err;
      logic                     unconfigured;
   } cmd_type;

endpackage

@@ src/esv_channels.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on esv_pkg for the payload types.
interface esv_req_if;
   logic             valid;
   logic             ready;
   esv_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface esv_rsp_if;
   logic             valid;
   logic             ready;
   esv_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ src/encoder_sample_validator.sv @@
// Path: an accepted request word is written into the queue, and the back end then
// registers its response word in the output register, where it waits to be taken.
// Throughput: one word per cycle while the response channel is ready; a stalled
// response fills the two-entry queue that decouples the ends, then req_ready drops.
// Reset: port types none, window length 10000, threshold 0, error counters and
// window counter cleared by the reset itself; no clearing pass.
module encoder_sample_validator #(
   parameter int PORTS        = esv_pkg::PORTS_DEFAULT,
   parameter int ERROR_KINDS  = esv_pkg::ERROR_KINDS_DEFAULT,
   parameter int COUNTER_BITS = esv_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [$clog2(PORTS + 2)-1:0]         csr_index,
   input  logic [esv_pkg::CSR_DATA_BITS-1:0]    csr_data,
   esv_req_if.sink                              req_ch,
   esv_rsp_if.source                            rsp_ch
);
   import esv_pkg::*;

   localparam int IDX_W = $clog2(PORTS + 2);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_cmd;

   esv_front #(
      .PORTS (PORTS),
      .IDX_W (IDX_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   esv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   esv_back #(
      .PORTS        (PORTS),
      .ERROR_KINDS  (ERROR_KINDS),
      .COUNTER_BITS (COUNTER_BITS),
      .IDX_W        (IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd_valid   (pop_valid),
      .cmd         (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload)
   );

endmodule

@@ src/esv_front.sv @@
// Front end: accepts request words, holds the port type registers, classifies.
// Depends on esv_pkg; feeds esv_queue.
module esv_front #(
   parameter int PORTS = esv_pkg::PORTS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [IDX_W-1:0]                 csr_index,
   input  logic [esv_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  esv_pkg::req_type                 req_payload,
   output logic                             push,
   output esv_pkg::cmd_type                 push_cmd,
   input  logic                             queue_full
);
   import esv_pkg::*;

   logic [PORT_TYPE_BITS-1:0] port_type_ff [PORTS];
   logic [PORT_TYPE_BITS-1:0] sel_type;
   logic                      parity_odd;
   logic                      status_bad;

   for (genvar p = 0; p < PORTS; p++) begin : g_ptype
      always_ff @(posedge clock) begin
         if (reset) begin
            port_type_ff[p] <= PTYPE_NONE;
         end else if (csr_we && csr_index == IDX_W'(p)) begin
            port_type_ff[p] <= csr_data[PORT_TYPE_BITS-1:0];
         end
      end
   end

   // ports beyond the configured range read as unconfigured
   always_comb begin
      sel_type = PTYPE_NONE;
      for (int p = 0; p < PORTS; p++) begin
         if (int'(req_payload.port) == p) begin
            sel_type = port_type_ff[p];
         end
      end
   end

   assign parity_odd = ^req_payload.raw_word[PARITY_SPAN-1:0];
   assign status_bad = req_payload.raw_word[5:3] != STATUS_GOOD;

   always_comb begin
      push_cmd              = '0;
      push_cmd.tick         = req_payload.operation == OP_TICK;
      push_cmd.port         = req_payload.port;
      if (req_payload.operation == OP_SAMPLE) begin
         case (sel_type)
            PTYPE_PARITY: begin
               push_cmd.link_err   = !req_payload.link_ok;
               push_cmd.parity_err = parity_odd;
               // parity wins over a bad status field
               push_cmd.status_err = !parity_odd && status_bad;
               push_cmd.position   = {req_payload.raw_word[17:6], 4'b0000};
            end
            PTYPE_PLAIN: begin
               push_cmd.link_err   = !req_payload.link_ok;
               push_cmd.position   = req_payload.raw_word[19:4];
            end
            default: begin
               push_cmd.unconfigured = 1'b1;
            end
         endcase
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

@@ src/esv_queue.sv @@
// Short queue of classified items between the front and back ends.
// Depends on esv_pkg for cmd_type and the queue depth.
module esv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  esv_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output esv_pkg::cmd_type pop_cmd
);
   import esv_pkg::*;

   cmd_type                   store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full      = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = store_ff[rd_ptr_ff];

endmodule

@@ src/esv_back.sv @@
// Back end: error counters, window counter, alarm judgement and response register.
// Depends on esv_pkg; takes items from esv_queue.
module esv_back #(
   parameter int PORTS        = esv_pkg::PORTS_DEFAULT,
   parameter int ERROR_KINDS  = esv_pkg::ERROR_KINDS_DEFAULT,
   parameter int COUNTER_BITS = esv_pkg::COUNTER_BITS_DEFAULT,
   parameter int IDX_W        = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [IDX_W-1:0]                 csr_index,
   input  logic [esv_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                             cmd_valid,
   input  esv_pkg::cmd_type                 cmd,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output esv_pkg::rsp_type                 rsp_payload
);
   import esv_pkg::*;

   localparam int NUM_CNT = PORTS * ERROR_KINDS;
   localparam int CMP_W   = (COUNTER_BITS > THRESHOLD_BITS) ? COUNTER_BITS : THRESHOLD_BITS;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

   logic [WINDOW_BITS-1:0]    win_len_ff, win_len_in;
   logic [THRESHOLD_BITS-1:0] thresh_ff, thresh_in;
   logic [WINDOW_BITS-1:0]    win_cnt_ff, win_cnt_in;
   logic [COUNTER_BITS-1:0]   cnt_ff [NUM_CNT];
   logic [COUNTER_BITS-1:0]   cnt_in [NUM_CNT];
   logic [NUM_CNT-1:0]        over_ff, over_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;
   logic                      judge;
   logic                      clear_all;

   always_comb begin
      win_len_in = win_len_ff;
      thresh_in  = thresh_ff;
      if (csr_we && csr_index == IDX_W'(PORTS)) begin
         win_len_in = csr_data[WINDOW_BITS-1:0];
      end
      if (csr_we && csr_index == IDX_W'(PORTS + 1)) begin
         thresh_in = csr_data[THRESHOLD_BITS-1:0];
      end
   end

   // advance when the output register is free or being drained
   assign pop       = cmd_valid && (!out_valid_ff || rsp_ready);
   assign judge     = !(win_cnt_ff < win_len_ff);
   assign clear_all = pop && cmd.tick && judge;

   for (genvar p = 0; p < PORTS; p++) begin : g_port
      for (genvar k = 0; k < ERROR_KINDS; k++) begin : g_kind
         localparam int I = p * ERROR_KINDS + k;
         logic hit;
         logic bump;

         always_comb begin
            case (k)
               KIND_LINK:   hit = cmd.link_err;
               KIND_PARITY: hit = cmd.parity_err;
               KIND_STATUS: hit = cmd.status_err;
               default:     hit = 1'b0;
            endcase
         end

         assign bump = pop && !cmd.tick && !cmd.unconfigured && int'(cmd.port) == p && hit;

         always_comb begin
            cnt_in[I] = cnt_ff[I];
            if (clear_all) begin
               cnt_in[I] = '0;
            end else if (bump && cnt_ff[I] != CNT_MAX) begin
               cnt_in[I] = cnt_ff[I] + 1'b1;
            end
         end

         // keep the over-threshold flag in step with counter and threshold
         assign over_in[I] = CMP_W'(cnt_in[I]) > CMP_W'(thresh_in);

         always_ff @(posedge clock) begin
            if (reset) begin
               cnt_ff[I]  <= '0;
               over_ff[I] <= 1'b0;
            end else begin
               cnt_ff[I]  <= cnt_in[I];
               over_ff[I] <= over_in[I];
            end
         end
      end
   end

   always_comb begin
      win_cnt_in = win_cnt_ff;
      out_in     = '0;
      if (cmd.tick) begin
         win_cnt_in = judge ? '0 : win_cnt_ff + 1'b1;
         out_in.alarm = judge && (|over_ff);
      end else begin
         out_in.position     = cmd.position;
         out_in.check_error  = cmd.parity_err || cmd.status_err;
         out_in.link_error   = cmd.link_err;
         out_in.unconfigured = cmd.unconfigured;
      end
      out_in.window_count = win_cnt_in;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff   <= WINDOW_LENGTH_RESET;
         thresh_ff    <= '0;
         win_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         win_len_ff   <= win_len_in;
         thresh_ff    <= thresh_in;
         out_valid_ff <= out_valid_in;
         if (pop) begin
            win_cnt_ff <= win_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ src/esv_checker.sv @@
// Port-level checks on the response channel of the encoder sample validator.
// Depends on esv_pkg and encoder_sample_validator_macros.svh; bound to the top level.
`include "encoder_sample_validator_macros.svh"

module esv_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input esv_pkg::rsp_type rsp_payload
);
   import esv_pkg::*;

   `ESV_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `ESV_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "stalled response changed")
   `ESV_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response valid right after reset")
   `ESV_ASSERT(a_uncfg_clean, rsp_valid && rsp_payload.unconfigured |-> rsp_payload.position == '0 && !rsp_payload.check_error && !rsp_payload.link_error && !rsp_payload.alarm, "unconfigured word carries data")
   `ESV_ASSERT(a_alarm_clears, rsp_valid && rsp_payload.alarm |-> rsp_payload.window_count == '0 && !rsp_payload.check_error && !rsp_payload.link_error, "alarm without window restart")

endmodule

bind encoder_sample_validator esv_checker u_esv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
